### hdl/cit_pkg.sv
// ----------------------------------------------------------------------------
// cit_pkg
// Types and codes shared by the content index table and its test bench.
// ----------------------------------------------------------------------------
package cit_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int RANK_W      = 6;
   localparam int COUNT_W     = 16;

   localparam logic [1:0] REQ_REGISTER   = 2'd0;
   localparam logic [1:0] REQ_SEARCH     = 2'd1;
   localparam logic [1:0] REQ_DEREGISTER = 2'd2;
   localparam logic [1:0] REQ_LIST       = 2'd3;

   localparam logic [3:0] RESP_REGISTERED = 4'd0;
   localparam logic [3:0] RESP_DELETED    = 4'd1;
   localparam logic [3:0] RESP_FOUND      = 4'd2;
   localparam logic [3:0] RESP_LIST_ITEM  = 4'd3;
   localparam logic [3:0] RESP_DUPLICATE  = 4'd4;
   localparam logic [3:0] RESP_SEARCH_MISS = 4'd5;
   localparam logic [3:0] RESP_DEREG_MISS = 4'd6;
   localparam logic [3:0] RESP_EMPTY      = 4'd7;
   localparam logic [3:0] RESP_FULL       = 4'd8;

   typedef struct packed {
      logic [63:0]        peer_lo;
      logic [7:0]         peer_hi;
      logic [63:0]        content_lo;
      logic [7:0]         content_hi;
      logic [31:0]        address;
      logic [15:0]        port;
      logic [COUNT_W-1:0] use_count;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_ACT,
      ST_LIST_RD,
      ST_LIST_OUT
   } state_type;

endpackage

### hdl/cit_ram.sv
// ----------------------------------------------------------------------------
// cit_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/content_index_table_least_used_unit.sv
// ----------------------------------------------------------------------------
// content_index_table_least_used_unit
// Directory of (peer, content) registrations with least-used search.
// ----------------------------------------------------------------------------
// Usage: drive the req_ ports and raise start while busy is low; the item is
// taken at that edge and busy stays high until the item's last result.
// Each result sits on the rsp_ ports for one cycle with rsp_valid high;
// rsp_last_item marks the final result of the item. The receiver cannot
// stall, so results are never held back.
// Register, search and deregister each read every slot of the entry RAM
// once (one read port, one slot per cycle), then pass the scan-end state
// and act on the outcome in the act state; the single result is registered
// and busy drops with it. List all skips the scan: each entry is a rank
// lookup plus RAM read, then a registered result, newest first; an empty
// table has its one result decided in the read state. A new item may be
// taken in the cycle of the last result.
// Reset clears the valid bits, so the table comes up empty at once with
// no clearing pass; entry payload needs no reset.
// ----------------------------------------------------------------------------
module content_index_table_least_used_unit #(
   parameter int ENTRIES = cit_pkg::ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_peer_name_lo,
   input  logic [7:0]  req_peer_name_hi,
   input  logic [63:0] req_content_name_lo,
   input  logic [7:0]  req_content_name_hi,
   input  logic [31:0] req_server_address,
   input  logic [15:0] req_server_port,
   output logic        rsp_valid,
   output logic [3:0]  rsp_resp_code,
   output logic [63:0] rsp_out_peer_lo,
   output logic [7:0]  rsp_out_peer_hi,
   output logic [63:0] rsp_out_content_lo,
   output logic [7:0]  rsp_out_content_hi,
   output logic [31:0] rsp_out_address,
   output logic [15:0] rsp_out_port,
   output logic        rsp_last_item
);
   import cit_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [RANK_W-1:0]  rank_ff [ENTRIES];
   logic [RANK_W-1:0]  rank_in [ENTRIES];

   logic [1:0]  type_ff, type_in;
   logic [63:0] plo_ff, plo_in, clo_ff, clo_in;
   logic [7:0]  phi_ff, phi_in, chi_ff, chi_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] port_ff, port_in;

   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0] pipe_idx_ff, pipe_idx_in;

   logic             pair_hit_ff, pair_hit_in;
   logic [IDX_W-1:0] pair_idx_ff, pair_idx_in;
   logic             best_hit_ff, best_hit_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [RANK_W-1:0] best_rank_ff, best_rank_in;
   row_type          best_row_ff, best_row_in;

   logic [RANK_W-1:0] list_rank_ff, list_rank_in;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic [IDX_W-1:0]  list_idx;

   logic        out_vld_ff, out_vld_in;
   logic [3:0]  out_code_ff, out_code_in;
   row_type     out_row_ff, out_row_in;
   logic        out_last_ff, out_last_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   row_type          ram_wdata, ram_rdata;
   logic [ROW_W-1:0] ram_rdata_bits;

   logic             free_hit;
   logic [IDX_W-1:0] free_idx;
   logic [CNT_W-1:0] num_valid;
   logic             cmp_valid, pair_match, cont_match, better;

   cit_ram #(.WIDTH(ROW_W), .DEPTH(ENTRIES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_bits)
   );
   assign ram_rdata = row_type'(ram_rdata_bits);

   // lowest free slot, valid count and slot holding the current list rank
   always_comb begin
      free_hit  = 1'b0;
      free_idx  = '0;
      num_valid = '0;
      list_idx  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = IDX_W'(i);
         end
         if (valid_ff[i] && rank_ff[i] == list_rank_ff) begin
            list_idx = IDX_W'(i);
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         num_valid = num_valid + CNT_W'(valid_ff[i]);
      end
   end

   always_comb begin
      cmp_valid  = pipe_vld_ff && valid_ff[pipe_idx_ff];
      cont_match = cmp_valid && ram_rdata.content_lo == clo_ff &&
                   ram_rdata.content_hi == chi_ff;
      pair_match = cont_match && ram_rdata.peer_lo == plo_ff &&
                   ram_rdata.peer_hi == phi_ff;
      better     = !best_hit_ff || ram_rdata.use_count < best_row_ff.use_count ||
                   (ram_rdata.use_count == best_row_ff.use_count &&
                    rank_ff[pipe_idx_ff] < best_rank_ff);
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      rank_in      = rank_ff;
      type_in      = type_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      clo_in       = clo_ff;
      chi_in       = chi_ff;
      addr_in      = addr_ff;
      port_in      = port_ff;
      scan_idx_in  = scan_idx_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = scan_idx_ff;
      pair_hit_in  = pair_hit_ff;
      pair_idx_in  = pair_idx_ff;
      best_hit_in  = best_hit_ff;
      best_idx_in  = best_idx_ff;
      best_rank_in = best_rank_ff;
      best_row_in  = best_row_ff;
      list_rank_in = list_rank_ff;
      num_in       = num_ff;
      out_vld_in   = 1'b0;
      out_code_in  = out_code_ff;
      out_row_in   = '0;
      out_last_in  = 1'b1;
      ram_we       = 1'b0;
      ram_waddr    = free_idx;
      ram_wdata    = '0;
      ram_raddr    = scan_idx_ff;

      // compare stage: one slot's RAM data per cycle
      if (pair_match && !pair_hit_ff) begin
         pair_hit_in = 1'b1;
         pair_idx_in = pipe_idx_ff;
      end
      if (cont_match && better) begin
         best_hit_in  = 1'b1;
         best_idx_in  = pipe_idx_ff;
         best_rank_in = rank_ff[pipe_idx_ff];
         best_row_in  = ram_rdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               type_in      = req_type;
               plo_in       = req_peer_name_lo;
               phi_in       = req_peer_name_hi;
               clo_in       = req_content_name_lo;
               chi_in       = req_content_name_hi;
               addr_in      = req_server_address;
               port_in      = req_server_port;
               scan_idx_in  = '0;
               pair_hit_in  = 1'b0;
               best_hit_in  = 1'b0;
               list_rank_in = '0;
               num_in       = num_valid;
               state_in     = (req_type == REQ_LIST) ? ST_LIST_RD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            pipe_vld_in = 1'b1;
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (scan_idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_ACT;
         end
         ST_ACT: begin
            out_vld_in = 1'b1;
            state_in   = ST_IDLE;
            case (type_ff)
               REQ_REGISTER: begin
                  if (pair_hit_ff) begin
                     out_code_in = RESP_DUPLICATE;
                  end else if (!free_hit) begin
                     out_code_in = RESP_FULL;
                  end else begin
                     out_code_in          = RESP_REGISTERED;
                     ram_we               = 1'b1;
                     ram_waddr            = free_idx;
                     ram_wdata.peer_lo    = plo_ff;
                     ram_wdata.peer_hi    = phi_ff;
                     ram_wdata.content_lo = clo_ff;
                     ram_wdata.content_hi = chi_ff;
                     ram_wdata.address    = addr_ff;
                     ram_wdata.port       = port_ff;
                     ram_wdata.use_count  = '0;
                     for (int i = 0; i < ENTRIES; i++) begin
                        if (valid_ff[i]) begin
                           rank_in[i] = rank_ff[i] + RANK_W'(1);
                        end
                     end
                     rank_in[free_idx]  = '0;
                     valid_in[free_idx] = 1'b1;
                  end
               end
               REQ_SEARCH: begin
                  if (!best_hit_ff) begin
                     out_code_in = RESP_SEARCH_MISS;
                  end else begin
                     out_code_in        = RESP_FOUND;
                     ram_we             = 1'b1;
                     ram_waddr          = best_idx_ff;
                     ram_wdata          = best_row_ff;
                     if (best_row_ff.use_count != '1) begin
                        ram_wdata.use_count = best_row_ff.use_count + COUNT_W'(1);
                     end
                     out_row_in.peer_lo = best_row_ff.peer_lo;
                     out_row_in.peer_hi = best_row_ff.peer_hi;
                     out_row_in.address = best_row_ff.address;
                     out_row_in.port    = best_row_ff.port;
                  end
               end
               REQ_DEREGISTER: begin
                  if (!pair_hit_ff) begin
                     out_code_in = RESP_DEREG_MISS;
                  end else begin
                     out_code_in = RESP_DELETED;
                     for (int i = 0; i < ENTRIES; i++) begin
                        if (valid_ff[i] && rank_ff[i] > rank_ff[pair_idx_ff]) begin
                           rank_in[i] = rank_ff[i] - RANK_W'(1);
                        end
                     end
                     valid_in[pair_idx_ff] = 1'b0;
                  end
               end
               default: begin
                  out_code_in = RESP_EMPTY;
               end
            endcase
         end
         ST_LIST_RD: begin
            ram_raddr = list_idx;
            if (num_ff == '0) begin
               out_vld_in  = 1'b1;
               out_code_in = RESP_EMPTY;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_LIST_OUT;
            end
         end
         ST_LIST_OUT: begin
            out_vld_in            = 1'b1;
            out_code_in           = RESP_LIST_ITEM;
            out_row_in.peer_lo    = ram_rdata.peer_lo;
            out_row_in.peer_hi    = ram_rdata.peer_hi;
            out_row_in.content_lo = ram_rdata.content_lo;
            out_row_in.content_hi = ram_rdata.content_hi;
            out_last_in  = (CNT_W + 1)'(list_rank_ff) + (CNT_W + 1)'(1) ==
                           (CNT_W + 1)'(num_ff);
            list_rank_in = list_rank_ff + RANK_W'(1);
            state_in     = out_last_in ? ST_IDLE : ST_LIST_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         pipe_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         pipe_vld_ff <= pipe_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      rank_ff      <= rank_in;
      type_ff      <= type_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      clo_ff       <= clo_in;
      chi_ff       <= chi_in;
      addr_ff      <= addr_in;
      port_ff      <= port_in;
      scan_idx_ff  <= scan_idx_in;
      pipe_idx_ff  <= pipe_idx_in;
      pair_hit_ff  <= pair_hit_in;
      pair_idx_ff  <= pair_idx_in;
      best_hit_ff  <= best_hit_in;
      best_idx_ff  <= best_idx_in;
      best_rank_ff <= best_rank_in;
      best_row_ff  <= best_row_in;
      list_rank_ff <= list_rank_in;
      num_ff       <= num_in;
      out_code_ff  <= out_code_in;
      out_row_ff   <= out_row_in;
      out_last_ff  <= out_last_in;
   end

   assign busy               = state_ff != ST_IDLE;
   assign rsp_valid          = out_vld_ff;
   assign rsp_resp_code      = out_code_ff;
   assign rsp_out_peer_lo    = out_row_ff.peer_lo;
   assign rsp_out_peer_hi    = out_row_ff.peer_hi;
   assign rsp_out_content_lo = out_row_ff.content_lo;
   assign rsp_out_content_hi = out_row_ff.content_hi;
   assign rsp_out_address    = out_row_ff.address;
   assign rsp_out_port       = out_row_ff.port;
   assign rsp_last_item      = out_last_ff;

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_item |-> !busy)
      else $error("busy still high after last result");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_multi_is_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_item |-> rsp_resp_code == RESP_LIST_ITEM)
      else $error("non-final result that is not a list item");

   a_write_in_act: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_ACT)
      else $error("RAM write outside the act step");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the content index table. Items are issued from a
// queue through start/busy; a local table model predicts every response and
// each strobed result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cit_pkg::*;

   localparam int NSLOT = ENTRIES_DEF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] plo;
      logic [7:0]  phi;
      logic [63:0] clo;
      logic [7:0]  chi;
      logic [31:0] addr;
      logic [15:0] port;
   } req_item_t;

   typedef struct packed {
      logic [3:0]  code;
      logic [63:0] plo;
      logic [7:0]  phi;
      logic [63:0] clo;
      logic [7:0]  chi;
      logic [31:0] addr;
      logic [15:0] port;
      logic        last;
   } rsp_item_t;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid, rsp_last_item;
   logic [1:0]  req_type = '0;
   logic [63:0] req_peer_name_lo = '0, req_content_name_lo = '0;
   logic [7:0]  req_peer_name_hi = '0, req_content_name_hi = '0;
   logic [31:0] req_server_address = '0;
   logic [15:0] req_server_port = '0;
   logic [3:0]  rsp_resp_code;
   logic [63:0] rsp_out_peer_lo, rsp_out_content_lo;
   logic [7:0]  rsp_out_peer_hi, rsp_out_content_hi;
   logic [31:0] rsp_out_address;
   logic [15:0] rsp_out_port;

   content_index_table_least_used_unit dut (.*);

   always #5 clock = ~clock;

   // table model
   bit          tv[NSLOT];
   req_item_t   te[NSLOT];
   logic [15:0] tuse[NSLOT];
   int          tage[NSLOT];

   req_item_t pending_items[$];
   rsp_item_t expected_rsps[$];
   int   errors = 0, n_rsps = 0, idle_pct = 0;
   int   code_seen[9];
   bit   feeding_done = 0;

   function automatic rsp_item_t blank(logic [3:0] c);
      rsp_item_t r = '0;
      r.code = c;
      r.last = 1;
      return r;
   endfunction

   function automatic int pair_slot(req_item_t q);
      for (int i = 0; i < NSLOT; i++)
         if (tv[i] && te[i].plo == q.plo && te[i].phi == q.phi &&
             te[i].clo == q.clo && te[i].chi == q.chi) return i;
      return -1;
   endfunction

   task automatic predict_table(req_item_t q);
      int hit, n;
      rsp_item_t r;
      hit = -1;
      n = 0;
      case (q.kind)
         REQ_REGISTER: begin
            if (pair_slot(q) >= 0) expected_rsps.push_back(blank(RESP_DUPLICATE));
            else begin
               for (int i = NSLOT - 1; i >= 0; i--) if (!tv[i]) hit = i;
               if (hit < 0) expected_rsps.push_back(blank(RESP_FULL));
               else begin
                  for (int i = 0; i < NSLOT; i++) if (tv[i]) tage[i]++;
                  tv[hit] = 1; te[hit] = q; tuse[hit] = 0; tage[hit] = 0;
                  expected_rsps.push_back(blank(RESP_REGISTERED));
               end
            end
         end
         REQ_SEARCH: begin
            for (int i = 0; i < NSLOT; i++)
               if (tv[i] && te[i].clo == q.clo && te[i].chi == q.chi)
                  if (hit < 0 || tuse[i] < tuse[hit] ||
                      (tuse[i] == tuse[hit] && tage[i] < tage[hit])) hit = i;
            if (hit < 0) expected_rsps.push_back(blank(RESP_SEARCH_MISS));
            else begin
               if (tuse[hit] != 16'hFFFF) tuse[hit]++;
               r = blank(RESP_FOUND);
               r.plo = te[hit].plo; r.phi = te[hit].phi;
               r.addr = te[hit].addr; r.port = te[hit].port;
               expected_rsps.push_back(r);
            end
         end
         REQ_DEREGISTER: begin
            hit = pair_slot(q);
            if (hit < 0) expected_rsps.push_back(blank(RESP_DEREG_MISS));
            else begin
               tv[hit] = 0;
               for (int i = 0; i < NSLOT; i++)
                  if (tv[i] && tage[i] > tage[hit]) tage[i]--;
               expected_rsps.push_back(blank(RESP_DELETED));
            end
         end
         default: begin
            for (int i = 0; i < NSLOT; i++) n += tv[i];
            if (n == 0) expected_rsps.push_back(blank(RESP_EMPTY));
            for (int k = 0; k < n; k++)
               for (int i = 0; i < NSLOT; i++)
                  if (tv[i] && tage[i] == k) begin
                     r = blank(RESP_LIST_ITEM);
                     r.plo = te[i].plo; r.phi = te[i].phi;
                     r.clo = te[i].clo; r.chi = te[i].chi;
                     r.last = (k == n - 1);
                     expected_rsps.push_back(r);
                  end
         end
      endcase
   endtask

   // driver: hold start until accepted, then idle at random
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            predict_table({req_type, req_peer_name_lo, req_peer_name_hi,
                           req_content_name_lo, req_content_name_hi,
                           req_server_address, req_server_port});
         end
         if (!(start && busy)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_item_t q;
               q = pending_items.pop_front();
               start <= 1;
               {req_type, req_peer_name_lo, req_peer_name_hi, req_content_name_lo,
                req_content_name_hi, req_server_address, req_server_port} <= q;
            end else begin
               start <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_t got, exp_r;
      if (!reset && rsp_valid) begin
         got = {rsp_resp_code, rsp_out_peer_lo, rsp_out_peer_hi, rsp_out_content_lo,
                rsp_out_content_hi, rsp_out_address, rsp_out_port, rsp_last_item};
         n_rsps++;
         if (rsp_resp_code <= RESP_FULL) code_seen[rsp_resp_code]++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
         end else begin
            exp_r = expected_rsps.pop_front();
            if (got !== exp_r) begin
               errors++;
               $display("%0t: mismatch, expected %h, actual %h", $time, exp_r, got);
            end
         end
      end
   end

   // small name pool so duplicates, hits and deletes are common
   function automatic req_item_t pick(logic [1:0] k);
      req_item_t q;
      int p, c;
      p = $urandom_range(5);
      c = $urandom_range(3);
      q.kind = k;
      q.plo  = (p == 5) ? {$urandom, $urandom} : 64'h5045_4552_0000_0000 | 64'(p);
      q.phi  = (p == 4) ? 8'hFF : 8'h00;
      q.clo  = (c == 3) ? {$urandom, $urandom} : 64'hC0DE_0000_0000_0000 | 64'(c);
      q.chi  = (c == 2) ? 8'hA5 : 8'h00;
      q.addr = $urandom;
      q.port = 16'($urandom);
      if ($urandom_range(9) == 0) begin
         q.phi = 8'($urandom); q.chi = 8'($urandom);
      end
      return q;
   endfunction

   task automatic add_item(logic [1:0] k, logic [63:0] plo, logic [7:0] phi,
                           logic [63:0] clo, logic [7:0] chi,
                           logic [31:0] addr, logic [15:0] port);
      pending_items.push_back({k, plo, phi, clo, chi, addr, port});
   endtask

   initial begin
      int draw;
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed: empty list, misses, extremes, fill past full, duplicate
      add_item(REQ_LIST, '0, '0, '0, '0, '0, '0);
      add_item(REQ_SEARCH, '0, '0, '0, '0, '0, '0);
      add_item(REQ_DEREGISTER, '0, '0, '0, '0, '0, '0);
      add_item(REQ_REGISTER, '1, '1, '1, '1, '1, '1);
      add_item(REQ_REGISTER, '1, '1, '1, '1, '0, '0);
      add_item(REQ_REGISTER, '0, '0, '1, '1, 32'h0A000001, 16'd80);
      add_item(REQ_SEARCH, 64'd1, 8'd1, '1, '1, '0, '0);
      add_item(REQ_SEARCH, '0, '0, '1, '1, '0, '0);
      for (int i = 0; i < 15; i++)
         add_item(REQ_REGISTER, 64'(i), 8'h11, 64'(i), 8'h00, 32'(i), 16'(i));
      add_item(REQ_LIST, '0, '0, '0, '0, '0, '0);
      add_item(REQ_DEREGISTER, '0, '0, '1, '1, '0, '0);
      add_item(REQ_LIST, '0, '0, '0, '0, '0, '0);
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 72 : (ph == 3 ? 8 : 0);
         for (int n = 0; n < 40; n++) begin
            draw = $urandom_range(99);
            pending_items.push_back(pick(draw < 40 ? REQ_REGISTER :
                                         draw < 70 ? REQ_SEARCH :
                                         draw < 92 ? REQ_DEREGISTER : REQ_LIST));
         end
         // in phase 2 only, queue 30 extra deregisters so the table can empty again
         if (ph == 2)
            for (int n = 0; n < 30; n++) pending_items.push_back(pick(REQ_DEREGISTER));
         while (pending_items.size() > 0) @(posedge clock);
      end
      // saturate a use count: 65535 searches are too many, so stop here
      while (pending_items.size() > 0 || start || busy || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Covered %0d results: registered %0d found %0d listed %0d full %0d",
               n_rsps, code_seen[0], code_seen[2], code_seen[3], code_seen[8]);
      $display("duplicates %0d, misses %0d/%0d, empty lists %0d", code_seen[4],
               code_seen[5], code_seen[6], code_seen[7]);
      if (errors == 0 && expected_rsps.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end
endmodule

### filelist.f
hdl/cit_pkg.sv
hdl/cit_ram.sv
hdl/content_index_table_least_used_unit.sv
test/tb_top.sv
